[design/aer_pkg.sv]
// Shared types, constants and lookup tables of the anisotropic etch-rate cell.
// Used by every module in this folder; depends on nothing.
package aer_pkg;

  typedef enum logic [2:0] {
    REG_GRID  = 3'd0,
    REG_FLAT  = 3'd1,
    REG_SLOW  = 3'd2,
    REG_STEEP = 3'd3,
    REG_NANG  = 3'd4,
    REG_NWID  = 3'd5,
    REG_SEL   = 3'd6
  } aer_reg_e;

  typedef struct packed {
    logic signed [31:0] level_centre;
    logic signed [31:0] level_east;
    logic signed [31:0] level_west;
    logic signed [31:0] level_below;
    logic signed [31:0] level_above;
    logic               masked;
  } aer_in_t;

  typedef struct packed {
    logic [31:0] etch_rate;
    logic        in_band;
  } aer_out_t;

  typedef struct packed {
    logic [31:0] grid_spacing;
    logic [31:0] rate_flat;
    logic [31:0] rate_slow_plane;
    logic [31:0] rate_steep;
    logic [14:0] notch_angle;
    logic [14:0] notch_width;
    logic [31:0] mask_selectivity;
  } aer_cfg_t;

  // normalized gradient magnitudes
  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic        gzpos;
    logic        zero;
    logic [32:0] a;
    logic [32:0] b;
  } aer_norm_t;

  // rotation stage
  typedef struct packed {
    logic               vld;
    logic               band;
    logic               msk;
    logic               gzpos;
    logic               zero;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [24:0] z;
  } aer_rot_t;

  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic        dneg;
    logic [31:0] num;
    logic [14:0] rem;
    logic [31:0] quo;
  } aer_div_t;

  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic        dneg;
    logic [22:0] u;
  } aer_sq_t;

  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic        dneg;
    logic [24:0] e;
    logic [15:0] fr;
  } aer_exp_t;

  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic [56:0] p1;
    logic [24:0] om;
    logic [31:0] far;
  } aer_mix1_t;

  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic [56:0] p1;
    logic [56:0] p2;
  } aer_mix2_t;

  typedef struct packed {
    logic        vld;
    logic        band;
    logic        msk;
    logic [31:0] rate;
    logic [47:0] num;
    logic [31:0] rem;
    logic [47:0] quo;
  } aer_mdiv_t;

  localparam int CordicSteps = 16;
  localparam int ExpSteps    = 16;
  localparam int NDivStages  = 8;   // 4 quotient bits each, 32 bits
  localparam int MDivStages  = 12;  // 4 quotient bits each, 48 bits

  localparam logic [23:0] Deg90  = 24'(90 * 65536);
  localparam logic [23:0] Deg180 = 24'(180 * 65536);
  localparam logic [19:0] TMax   = 20'(8 * 65536);
  localparam logic [48:0] Half24 = 49'd8388608;
  localparam logic [24:0] One24  = 25'd16777216;

  localparam logic [22:0] ATAN_DEG [16] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115
  };

  localparam logic [24:0] EXP_INT [16] = '{
    25'd16777216, 25'd6171993, 25'd2270549, 25'd835288, 25'd307285, 25'd113044,
    25'd41587, 25'd15299, 25'd5628, 25'd2070, 25'd762, 25'd280,
    25'd103, 25'd38, 25'd14, 25'd5
  };

  // exp(-2^-k), k = 1..16
  localparam logic [23:0] EXP_FRAC [16] = '{
    24'd10175896, 24'd13066109, 24'd14805841, 24'd15760736, 24'd16261035,
    24'd16517109, 24'd16646655, 24'd16711808, 24'd16744480, 24'd16760840,
    24'd16769026, 24'd16773120, 24'd16775168, 24'd16776192, 24'd16776704,
    24'd16776960
  };

  // arithmetic shift that rounds toward zero
  function automatic logic signed [35:0] shr_tz(input logic signed [35:0] v,
                                                input logic [3:0] s);
    logic signed [35:0] n;
    n = -v;
    if (v[35]) begin
      return -(n >>> s);
    end
    return v >>> s;
  endfunction

endpackage

[design/anisotropic_etch_rate_cell.sv]
// Top level of the anisotropic etch-rate cell: register port, pipeline, output register.
// Uses aer_pkg and aer_front, aer_cordic, aer_notch, aer_mask.

// One cell beat is accepted every cycle while the output side keeps up; each result
// passes 3 normalize, 16 rotator, 27 notch divide, square and exp, 15 blend and mask
// divide stages and 1 output register. The whole pipeline advances together and
// holds when a result waits in the output register under stall. Registers must be
// written only while the pipeline is empty; the block itself does not enforce it.
module anisotropic_etch_rate_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  aer_pkg::aer_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aer_pkg::aer_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  aer_pkg::aer_cfg_t  cfg_q;
  aer_pkg::aer_norm_t norm;
  aer_pkg::aer_rot_t  rot;
  aer_pkg::aer_exp_t  ex;
  aer_pkg::aer_out_t  res, out_q;
  logic               res_vld, out_vld_q, en;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_spacing     <= 32'd65536;
      cfg_q.rate_flat        <= 32'd65536;
      cfg_q.rate_slow_plane  <= 32'd655;
      cfg_q.rate_steep       <= 32'd98304;
      cfg_q.notch_angle      <= 15'd14013;
      cfg_q.notch_width      <= 15'd1280;
      cfg_q.mask_selectivity <= 32'd6553600;
    end else if (psel && penable && pwrite) begin
      case (aer_pkg::aer_reg_e'(paddr[4:2]))
        aer_pkg::REG_GRID:  cfg_q.grid_spacing     <= pwdata;
        aer_pkg::REG_FLAT:  cfg_q.rate_flat        <= pwdata;
        aer_pkg::REG_SLOW:  cfg_q.rate_slow_plane  <= pwdata;
        aer_pkg::REG_STEEP: cfg_q.rate_steep       <= pwdata;
        aer_pkg::REG_NANG:  cfg_q.notch_angle      <= pwdata[14:0];
        aer_pkg::REG_NWID:  cfg_q.notch_width      <= pwdata[14:0];
        aer_pkg::REG_SEL:   cfg_q.mask_selectivity <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (aer_pkg::aer_reg_e'(paddr[4:2]))
      aer_pkg::REG_GRID:  prdata = cfg_q.grid_spacing;
      aer_pkg::REG_FLAT:  prdata = cfg_q.rate_flat;
      aer_pkg::REG_SLOW:  prdata = cfg_q.rate_slow_plane;
      aer_pkg::REG_STEEP: prdata = cfg_q.rate_steep;
      aer_pkg::REG_NANG:  prdata = {17'b0, cfg_q.notch_angle};
      aer_pkg::REG_NWID:  prdata = {17'b0, cfg_q.notch_width};
      aer_pkg::REG_SEL:   prdata = cfg_q.mask_selectivity;
      default:            prdata = '0;
    endcase
  end

  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  aer_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .in_i(in_data_i),
    .cfg_i(cfg_q), .norm_o(norm)
  );

  aer_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .norm_i(norm), .rot_o(rot)
  );

  aer_notch u_notch (
    .clk_i, .rst_ni, .en_i(en), .rot_i(rot), .cfg_i(cfg_q), .exp_o(ex)
  );

  aer_mask u_mask (
    .clk_i, .rst_ni, .en_i(en), .exp_i(ex), .cfg_i(cfg_q),
    .vld_o(res_vld), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[design/aer_front.sv]
// Band test, central differences and magnitude normalization (three stages).
// Uses aer_pkg types.
module aer_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  aer_pkg::aer_in_t   in_i,
  input  aer_pkg::aer_cfg_t  cfg_i,
  output aer_pkg::aer_norm_t norm_o
);

  aer_pkg::aer_norm_t a_d, a_q, b_d, b_q, c_d, c_q;

  logic signed [32:0] c_s, gx_s, gz_s;
  logic [32:0] mag;

  always_comb begin
    c_s  = $signed({in_i.level_centre[31], in_i.level_centre});
    gx_s = $signed({in_i.level_east[31], in_i.level_east})
         - $signed({in_i.level_west[31], in_i.level_west});
    gz_s = $signed({in_i.level_below[31], in_i.level_below})
         - $signed({in_i.level_above[31], in_i.level_above});
    mag  = c_s[32] ? 33'(-c_s) : 33'(c_s);
    a_d       = '0;
    a_d.vld   = vld_i;
    a_d.band  = ({2'b0, mag, 1'b0} <= ({4'b0, cfg_i.grid_spacing} * 36'd9));
    a_d.msk   = in_i.masked;
    a_d.gzpos = !gz_s[32] && (gz_s != '0);
    a_d.a     = gx_s[32] ? 33'(-gx_s) : 33'(gx_s);
    a_d.b     = gz_s[32] ? 33'(-gz_s) : 33'(gz_s);
  end

  // coarse shifts
  always_comb begin
    logic [32:0] m;
    b_d = a_q;
    m = (a_q.a > a_q.b) ? a_q.a : a_q.b;
    b_d.zero = (m == '0);
    if (m < 33'h0_0001_0000) begin
      m = m << 16; b_d.a = b_d.a << 16; b_d.b = b_d.b << 16;
    end
    if (m < 33'h0_0100_0000) begin
      b_d.a = b_d.a << 8; b_d.b = b_d.b << 8;
    end
  end

  // fine shifts, leaves the larger in [2^31, 2^33)
  always_comb begin
    logic [32:0] m;
    c_d = b_q;
    m = (b_q.a > b_q.b) ? b_q.a : b_q.b;
    if (m < 33'h0_1000_0000) begin
      m = m << 4; c_d.a = c_d.a << 4; c_d.b = c_d.b << 4;
    end
    if (m < 33'h0_4000_0000) begin
      m = m << 2; c_d.a = c_d.a << 2; c_d.b = c_d.b << 2;
    end
    if (m < 33'h0_8000_0000) begin
      c_d.a = c_d.a << 1; c_d.b = c_d.b << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  assign norm_o = c_q;

endmodule

[design/aer_cordic.sv]
// Vectoring rotator, one iteration per stage, angle accumulated in degrees Q16.16.
// Uses aer_pkg types, tables and shr_tz.
module aer_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  aer_pkg::aer_norm_t norm_i,
  output aer_pkg::aer_rot_t  rot_o
);

  aer_pkg::aer_rot_t st_d [aer_pkg::CordicSteps];
  aer_pkg::aer_rot_t st_q [aer_pkg::CordicSteps];
  aer_pkg::aer_rot_t first;

  always_comb begin
    first       = '0;
    first.vld   = norm_i.vld;
    first.band  = norm_i.band;
    first.msk   = norm_i.msk;
    first.gzpos = norm_i.gzpos;
    first.zero  = norm_i.zero;
    first.x     = $signed({3'b0, norm_i.b});
    first.y     = $signed({3'b0, norm_i.a});
  end

  for (genvar i = 0; i < aer_pkg::CordicSteps; i++) begin : g_step
    always_comb begin
      aer_pkg::aer_rot_t p;
      logic signed [35:0] xs, ys;
      logic signed [24:0] at;
      p  = (i == 0) ? first : st_q[(i == 0) ? 0 : i - 1];
      xs = aer_pkg::shr_tz(p.x, 4'(i));
      ys = aer_pkg::shr_tz(p.y, 4'(i));
      at = $signed({2'b0, aer_pkg::ATAN_DEG[i]});
      st_d[i] = p;
      if (!p.y[35] && (p.y != '0)) begin
        st_d[i].x = p.x + ys; st_d[i].y = p.y - xs; st_d[i].z = p.z + at;
      end else begin
        st_d[i].x = p.x - ys; st_d[i].y = p.y + xs; st_d[i].z = p.z - at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i] <= '0;
      end else if (en_i) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign rot_o = st_q[aer_pkg::CordicSteps-1];

endmodule

[design/aer_notch.sv]
// Angle offset, t = |d|/width by a 4-bit-per-stage divider, t^2 and exp(-t^2).
// Uses aer_pkg types and tables.
module aer_notch (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  aer_pkg::aer_rot_t rot_i,
  input  aer_pkg::aer_cfg_t cfg_i,
  output aer_pkg::aer_exp_t exp_o
);

  localparam int NSt = 1 + aer_pkg::NDivStages;

  aer_pkg::aer_div_t dv_d [NSt];
  aer_pkg::aer_div_t dv_q [NSt];
  aer_pkg::aer_sq_t  sq_d, sq_q;
  aer_pkg::aer_exp_t ex_d [aer_pkg::ExpSteps + 1];
  aer_pkg::aer_exp_t ex_q [aer_pkg::ExpSteps + 1];

  logic [14:0] nw;
  assign nw = (cfg_i.notch_width == '0) ? 15'd1 : cfg_i.notch_width;

  // angle and offset from the notch
  always_comb begin
    logic [23:0] base, ang, ad;
    logic signed [24:0] d;
    if (rot_i.z[24]) begin
      base = '0;
    end else if (rot_i.z > $signed({1'b0, aer_pkg::Deg90})) begin
      base = aer_pkg::Deg90;
    end else begin
      base = rot_i.z[23:0];
    end
    if (rot_i.zero) begin
      ang = aer_pkg::Deg90;
    end else if (rot_i.gzpos) begin
      ang = aer_pkg::Deg180 - base;
    end else begin
      ang = base;
    end
    d  = $signed({1'b0, ang}) - $signed({2'b0, cfg_i.notch_angle, 8'b0});
    ad = d[24] ? 24'(-d) : 24'(d);
    dv_d[0]      = '0;
    dv_d[0].vld  = rot_i.vld;
    dv_d[0].band = rot_i.band;
    dv_d[0].msk  = rot_i.msk;
    dv_d[0].dneg = d[24];
    dv_d[0].num  = {ad, 8'b0};
  end

  for (genvar j = 1; j < NSt; j++) begin : g_div
    always_comb begin
      logic [15:0] t16;
      dv_d[j] = dv_q[j-1];
      for (int b = 0; b < 4; b++) begin
        t16 = {dv_d[j].rem, dv_d[j].num[31]};
        dv_d[j].num = dv_d[j].num << 1;
        if (t16 >= {1'b0, nw}) begin
          t16 = t16 - {1'b0, nw};
          dv_d[j].quo = {dv_d[j].quo[30:0], 1'b1};
        end else begin
          dv_d[j].quo = {dv_d[j].quo[30:0], 1'b0};
        end
        dv_d[j].rem = t16[14:0];
      end
    end
  end

  for (genvar j = 0; j < NSt; j++) begin : g_divq
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= '0;
      end else if (en_i) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  // clamp and square
  always_comb begin
    logic [19:0] t;
    logic [39:0] sq;
    t = (dv_q[NSt-1].quo > {12'b0, aer_pkg::TMax}) ? aer_pkg::TMax
                                                    : dv_q[NSt-1].quo[19:0];
    sq        = {20'b0, t} * {20'b0, t};
    sq_d.vld  = dv_q[NSt-1].vld;
    sq_d.band = dv_q[NSt-1].band;
    sq_d.msk  = dv_q[NSt-1].msk;
    sq_d.dneg = dv_q[NSt-1].dneg;
    sq_d.u    = sq[38:16];
  end

  // integer part of the exponent from the table
  always_comb begin
    logic [6:0] n;
    n = sq_q.u[22:16];
    ex_d[0].vld  = sq_q.vld;
    ex_d[0].band = sq_q.band;
    ex_d[0].msk  = sq_q.msk;
    ex_d[0].dneg = sq_q.dneg;
    ex_d[0].e    = (n >= 7'd16) ? 25'd0 : aer_pkg::EXP_INT[n[3:0]];
    ex_d[0].fr   = sq_q.u[15:0];
  end

  // one fraction bit per stage
  for (genvar k = 1; k <= aer_pkg::ExpSteps; k++) begin : g_exp
    always_comb begin
      logic [48:0] pr;
      ex_d[k] = ex_q[k-1];
      pr = {24'b0, ex_q[k-1].e} * {25'b0, aer_pkg::EXP_FRAC[k-1]} + aer_pkg::Half24;
      if (ex_q[k-1].fr[aer_pkg::ExpSteps - k]) begin
        ex_d[k].e = pr[48:24];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0;
    end else if (en_i) begin
      sq_q <= sq_d;
    end
  end

  for (genvar k = 0; k <= aer_pkg::ExpSteps; k++) begin : g_expq
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_q[k] <= '0;
      end else if (en_i) begin
        ex_q[k] <= ex_d[k];
      end
    end
  end

  assign exp_o = ex_q[aer_pkg::ExpSteps];

endmodule

[design/aer_mask.sv]
// Rate blend of slow-plane and far rates; masked cells divide by mask selectivity.
// Uses aer_pkg types.
module aer_mask (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  aer_pkg::aer_exp_t exp_i,
  input  aer_pkg::aer_cfg_t cfg_i,
  output logic              vld_o,
  output aer_pkg::aer_out_t res_o
);

  aer_pkg::aer_mix1_t m1_d, m1_q;
  aer_pkg::aer_mix2_t m2_d, m2_q;
  aer_pkg::aer_mdiv_t dv_d [aer_pkg::MDivStages + 1];
  aer_pkg::aer_mdiv_t dv_q [aer_pkg::MDivStages + 1];

  always_comb begin
    m1_d.vld  = exp_i.vld;
    m1_d.band = exp_i.band;
    m1_d.msk  = exp_i.msk;
    m1_d.p1   = {25'b0, cfg_i.rate_slow_plane} * {32'b0, exp_i.e};
    m1_d.om   = aer_pkg::One24 - exp_i.e;
    m1_d.far  = exp_i.dneg ? cfg_i.rate_flat : cfg_i.rate_steep;
  end

  always_comb begin
    m2_d.vld  = m1_q.vld;
    m2_d.band = m1_q.band;
    m2_d.msk  = m1_q.msk;
    m2_d.p1   = m1_q.p1;
    m2_d.p2   = {25'b0, m1_q.far} * {32'b0, m1_q.om};
  end

  always_comb begin
    logic [57:0] s;
    s = {1'b0, m2_q.p1} + {1'b0, m2_q.p2} + {9'b0, aer_pkg::Half24};
    dv_d[0]      = '0;
    dv_d[0].vld  = m2_q.vld;
    dv_d[0].band = m2_q.band;
    dv_d[0].msk  = m2_q.msk;
    dv_d[0].rate = s[55:24];
    dv_d[0].num  = {s[55:24], 16'b0};
  end

  // zero selectivity yields an all-ones quotient, which saturates below
  for (genvar j = 1; j <= aer_pkg::MDivStages; j++) begin : g_div
    always_comb begin
      logic [32:0] t33;
      dv_d[j] = dv_q[j-1];
      for (int b = 0; b < 4; b++) begin
        t33 = {dv_d[j].rem, dv_d[j].num[47]};
        dv_d[j].num = dv_d[j].num << 1;
        if (t33 >= {1'b0, cfg_i.mask_selectivity}) begin
          t33 = t33 - {1'b0, cfg_i.mask_selectivity};
          dv_d[j].quo = {dv_d[j].quo[46:0], 1'b1};
        end else begin
          dv_d[j].quo = {dv_d[j].quo[46:0], 1'b0};
        end
        dv_d[j].rem = t33[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
    end else if (en_i) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

  for (genvar j = 0; j <= aer_pkg::MDivStages; j++) begin : g_divq
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= '0;
      end else if (en_i) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  always_comb begin
    aer_pkg::aer_mdiv_t l;
    l = dv_q[aer_pkg::MDivStages];
    vld_o         = l.vld;
    res_o.in_band = l.band;
    if (!l.band) begin
      res_o.etch_rate = '0;
    end else if (l.msk) begin
      res_o.etch_rate = (l.quo[47:32] != '0) ? 32'hFFFF_FFFF : l.quo[31:0];
    end else begin
      res_o.etch_rate = l.rate;
    end
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench of the anisotropic etch-rate cell: streams cell beats,
// predicts each rate in fixed point and checks every result beat in order.
// Depends on aer_pkg and the anisotropic_etch_rate_cell top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeLatency = 62;
  localparam longint CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  aer_pkg::aer_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  aer_pkg::aer_out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  anisotropic_etch_rate_cell u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the register file
  logic [31:0] dx_q, flat_q, slow_q, steep_q, sel_q;
  logic [14:0] nang_q, nwid_q;

  aer_pkg::aer_in_t  cell_q[$];
  aer_pkg::aer_out_t rate_q[$];
  int  mismatches = 0;
  bit  timed_out = 0;
  bit  no_idle = 0;
  longint cycles = 0;
  int  in_gap = 0, out_gap = 0;

  localparam longint AtanTab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
  localparam longint ExpWhole[16] = '{16777216, 6171993, 2270549, 835288, 307285,
    113044, 41587, 15299, 5628, 2070, 762, 280, 103, 38, 14, 5};
  localparam longint ExpBit[16] = '{10175896, 13066109, 14805841, 15760736, 16261035,
    16517109, 16646655, 16711808, 16744480, 16760840, 16769026, 16773120, 16775168,
    16776192, 16776704, 16776960};

  function automatic longint shift_tz(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic longint surface_angle(longint gx, longint gz);
    longint a, b, m, x, y, z, xs, ys, base;
    a = gx < 0 ? -gx : gx;
    b = gz < 0 ? -gz : gz;
    m = a > b ? a : b;
    z = 0;
    if (m == 0) return 90 * 65536;
    while (m < 64'h8000_0000) begin
      m = m << 1; a = a << 1; b = b << 1;
    end
    x = b; y = a;
    for (int i = 0; i < 16; i++) begin
      xs = shift_tz(x, i); ys = shift_tz(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += AtanTab[i];
      end else begin
        x -= ys; y += xs; z -= AtanTab[i];
      end
    end
    base = z < 0 ? 0 : (z > 90 * 65536 ? 90 * 65536 : z);
    return gz > 0 ? 180 * 65536 - base : base;
  endfunction

  function automatic aer_pkg::aer_out_t predict_rate(aer_pkg::aer_in_t c);
    aer_pkg::aer_out_t r;
    longint ctr, gx, gz, mag, ang, d;
    logic [63:0] nw, t, u, e, far, rate;
    ctr = longint'(c.level_centre);
    gx = longint'(c.level_east) - longint'(c.level_west);
    gz = longint'(c.level_below) - longint'(c.level_above);
    mag = ctr < 0 ? -ctr : ctr;
    r = '0;
    if (2 * mag > 9 * longint'({32'd0, dx_q})) return r;
    ang = surface_angle(gx, gz);
    d = ang - (longint'(nang_q) << 8);
    far = d < 0 ? 64'(flat_q) : 64'(steep_q);
    nw = nwid_q != 0 ? 64'(nwid_q) : 64'd1;
    t = (64'(d < 0 ? -d : d) << 8) / nw;
    if (t > 64'(8 * 65536)) t = 8 * 65536;
    u = (t * t) >> 16;
    if ((u >> 16) >= 16) e = 0;
    else begin
      e = ExpWhole[u >> 16];
      for (int k = 0; k < 16; k++)
        if (u[15 - k]) e = (e * ExpBit[k] + 64'd8388608) >> 24;
    end
    rate = (64'(slow_q) * e + far * (64'd16777216 - e) + 64'd8388608) >> 24;
    if (c.masked) begin
      if (sel_q == 0) rate = 64'hFFFF_FFFF;
      else begin
        rate = (rate << 16) / sel_q;
        if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
      end
    end
    r.etch_rate = rate[31:0];
    r.in_band = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit && !timed_out) begin
      timed_out = 1;
      $display("testbench: done, errors");
      $finish;
    end
  end

  // driver: a beat leaves only when accepted; payload holds under stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rate_q.push_back(predict_rate(in_data_i));
        void'(cell_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (cell_q.size() > 0) begin
          in_data_i <= cell_q[0];
          in_valid_i <= 1'b1;
          if (!no_idle && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 6);
        end else
          in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    aer_pkg::aer_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_data_o);
        end else begin
          want = rate_q.pop_front();
          if (out_data_o.etch_rate !== want.etch_rate || out_data_o.in_band !== want.in_band)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("rate mismatch: want %h/%b got %h/%b", want.etch_rate,
                       want.in_band, out_data_o.etch_rate, out_data_o.in_band);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else
        out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(aer_pkg::aer_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      aer_pkg::REG_GRID:  dx_q = val;
      aer_pkg::REG_FLAT:  flat_q = val;
      aer_pkg::REG_SLOW:  slow_q = val;
      aer_pkg::REG_STEEP: steep_q = val;
      aer_pkg::REG_NANG:  nang_q = val[14:0];
      aer_pkg::REG_NWID:  nwid_q = val[14:0];
      aer_pkg::REG_SEL:   sel_q = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (cell_q.size() != 0 || in_valid_i || rate_q.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  // near-surface cell with a random normal direction
  function automatic aer_pkg::aer_in_t shaped_cell(int reach);
    aer_pkg::aer_in_t c;
    int base;
    base = $urandom_range(0, 2 * reach) - reach;
    c.level_centre = base;
    c.level_east  = base + int'($urandom_range(0, 2 * reach)) - reach;
    c.level_west  = base + int'($urandom_range(0, 2 * reach)) - reach;
    c.level_below = base + int'($urandom_range(0, 2 * reach)) - reach;
    c.level_above = base + int'($urandom_range(0, 2 * reach)) - reach;
    c.masked = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic random_phase(int n);
    aer_pkg::aer_in_t c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: c = {rand32(), rand32(), rand32(), rand32(), rand32(), 1'($urandom())};
        1: begin
          c = shaped_cell(65536 * 4);
          c.level_east = c.level_centre; c.level_west = c.level_centre;
        end
        2: begin
          c = shaped_cell(65536 * 4);
          c.level_below = c.level_above;
        end
        default: c = shaped_cell($urandom_range(0, 1) ? 65536 * 5 : 4096);
      endcase
      cell_q.push_back(c);
    end
  endtask

  initial begin
    aer_pkg::aer_in_t c;
    dx_q = 65536; flat_q = 65536; slow_q = 655; steep_q = 98304;
    nang_q = 14013; nwid_q = 1280; sel_q = 6553600;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: band edges, zero gradient, field extremes, each orientation
    c = '0; cell_q.push_back(c);
    c.masked = 1; cell_q.push_back(c);
    c = '{32'sd294912, 32'sd294912, 32'sd294912, 32'sd294912, 32'sd294912, 1'b0};
    cell_q.push_back(c);
    c.level_centre = 294913; cell_q.push_back(c);
    c.level_centre = -294912; cell_q.push_back(c);
    c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 1'b1};
    cell_q.push_back(c);
    c = '{0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0};
    cell_q.push_back(c);
    c = '{-1, -1, -1, -1, -1, 1'b1}; cell_q.push_back(c);
    c = '{0, 65536, -65536, 0, 0, 1'b0}; cell_q.push_back(c);
    c = '{0, 0, 0, 65536, -65536, 1'b0}; cell_q.push_back(c);
    c = '{0, 0, 0, -65536, 65536, 1'b0}; cell_q.push_back(c);
    c = '{0, 65536, 0, 46341, 0, 1'b1}; cell_q.push_back(c);
    c = '{0, 65536, 0, 0, 46341, 1'b1}; cell_q.push_back(c);
    c = '{0, 1, 0, 0, 0, 1'b0}; cell_q.push_back(c);
    drain();

    // pressure: sender waits for every result before the next burst
    random_phase(150);
    drain();

    // extremes of the registers
    write_reg(aer_pkg::REG_GRID, 0);
    write_reg(aer_pkg::REG_SEL, 0);
    write_reg(aer_pkg::REG_NWID, 0);
    write_reg(aer_pkg::REG_NANG, 0);
    write_reg(aer_pkg::REG_FLAT, 32'hFFFF_FFFF);
    write_reg(aer_pkg::REG_STEEP, 32'hFFFF_FFFF);
    write_reg(aer_pkg::REG_SLOW, 32'hFFFF_FFFF);
    c = '0; cell_q.push_back(c);
    c.masked = 1; cell_q.push_back(c);
    c = '{1, 0, 0, 0, 0, 1'b1}; cell_q.push_back(c);
    random_phase(150);
    drain();

    write_reg(aer_pkg::REG_GRID, 32'hFFFF_FFFF);
    write_reg(aer_pkg::REG_SEL, 32'h0000_8000);
    write_reg(aer_pkg::REG_NWID, 23040);
    write_reg(aer_pkg::REG_NANG, 23040);
    write_reg(aer_pkg::REG_SLOW, 0);
    write_reg(aer_pkg::REG_FLAT, rand32());
    write_reg(aer_pkg::REG_STEEP, 0);
    random_phase(200);
    drain();

    write_reg(aer_pkg::REG_SEL, 32'hFFFF_FFFF);
    write_reg(aer_pkg::REG_NWID, 32'hFFFF_FFFF);
    write_reg(aer_pkg::REG_NANG, 32'hFFFF_7FFF);
    random_phase(100);
    drain();

    // random register settings within moderate ranges
    for (int p = 0; p < 4; p++) begin
      write_reg(aer_pkg::REG_GRID, $urandom_range(1, 32'h0004_0000));
      write_reg(aer_pkg::REG_FLAT, $urandom_range(0, 32'h0010_0000));
      write_reg(aer_pkg::REG_SLOW, $urandom_range(0, 32'h0001_0000));
      write_reg(aer_pkg::REG_STEEP, $urandom_range(0, 32'h0010_0000));
      write_reg(aer_pkg::REG_NANG, $urandom_range(0, 23040));
      write_reg(aer_pkg::REG_NWID, $urandom_range(1, 23040));
      write_reg(aer_pkg::REG_SEL, $urandom_range(65536, 32'h0100_0000));
      random_phase(200);
      drain();
    end

    // last part of the run: no idling on either side
    no_idle = 1;
    random_phase(300);
    drain();

    if (mismatches == 0 && rate_q.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule

[filelist.f]
design/aer_pkg.sv
design/aer_front.sv
design/aer_cordic.sv
design/aer_notch.sv
design/aer_mask.sv
design/anisotropic_etch_rate_cell.sv
tb/sv/testbench.sv
